FILE: rtl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg: shared types and constants of the grid path search
// Payload structs, controller/datapath command and status, step tables and
// the octile distance.
// ----------------------------------------------------------------------------
package gaps_pkg;

	localparam int STEP_STRAIGHT = 10;
	localparam int STEP_DIAGONAL = 14;
	localparam int COST_W        = 10;
	localparam int COORD_W       = 3;

	// item operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam logic REG_MAP_ROWS = 1'b0;
	localparam logic REG_MAP_COLS = 1'b1;

	// neighbour directions, (row step, column step)
	localparam logic [2:0] DIR_NW = 3'd0;
	localparam logic [2:0] DIR_N  = 3'd1;
	localparam logic [2:0] DIR_NE = 3'd2;
	localparam logic [2:0] DIR_W  = 3'd3;
	localparam logic [2:0] DIR_E  = 3'd4;
	localparam logic [2:0] DIR_SW = 3'd5;
	localparam logic [2:0] DIR_S  = 3'd6;
	localparam logic [2:0] DIR_SE = 3'd7;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic               wall;
		logic [COORD_W-1:0] goal_row;
		logic [COORD_W-1:0] goal_col;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] path_row;
		logic [COORD_W-1:0] path_col;
		logic               found;
		logic               last;
	} result_t;

	typedef struct packed {
		logic       index;
		logic [3:0] data;
	} cfg_t;

	typedef struct packed {
		logic [COST_W-1:0] g;
		logic [COST_W-1:0] f;
		logic [COST_W-1:0] stamp;
		logic [2:0]        parent;
	} node_t;

	typedef struct packed {
		logic load;
		logic start;
		logic init;
		logic scan;
		logic expand;
		logic nb;
		logic walk;
		logic emit_ld;
		logic fail;
	} cmd_t;

	typedef struct packed {
		logic oob;
		logic scan_done;
		logic best_valid;
		logic best_is_goal;
		logic nb_done;
		logic walk_done;
		logic emit_last;
		logic out_free;
	} status_t;

	function automatic logic signed [1:0] step_row(input logic [2:0] d);
		logic signed [1:0] s;
		case (d)
			DIR_NW, DIR_N, DIR_NE: s = -2'sd1;
			DIR_W, DIR_E:          s = 2'sd0;
			default:               s = 2'sd1;
		endcase
		return s;
	endfunction

	function automatic logic signed [1:0] step_col(input logic [2:0] d);
		logic signed [1:0] s;
		case (d)
			DIR_NW, DIR_W, DIR_SW: s = -2'sd1;
			DIR_N, DIR_S:          s = 2'sd0;
			default:               s = 2'sd1;
		endcase
		return s;
	endfunction

	function automatic logic [COST_W-1:0] octile(input logic [COORD_W-1:0] r0, c0, r1, c1);
		logic [COORD_W-1:0] dr, dc, lo, hi;
		dr = (r0 > r1) ? r0 - r1 : r1 - r0;
		dc = (c0 > c1) ? c0 - c1 : c1 - c0;
		lo = (dr < dc) ? dr : dc;
		hi = (dr < dc) ? dc : dr;
		return COST_W'(lo) * COST_W'(STEP_DIAGONAL) + COST_W'(hi - lo) * COST_W'(STEP_STRAIGHT);
	endfunction

endpackage

FILE: rtl/gaps_chan_if.sv
// ----------------------------------------------------------------------------
// gaps_chan_if: valid/ready channel
// One transfer per edge with valid and ready high; payload type is set per use.
// ----------------------------------------------------------------------------
interface gaps_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/gaps_ctrl.sv
// ----------------------------------------------------------------------------
// gaps_ctrl: search sequencer
// Steps the datapath through load, start, scan, expand, neighbour update,
// parent walk and path emission.
// ----------------------------------------------------------------------------
module gaps_ctrl
	import gaps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_op,
	output logic    item_ready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_PICK    = 4'd3;
	localparam logic [3:0] S_NB      = 4'd4;
	localparam logic [3:0] S_WALK    = 4'd5;
	localparam logic [3:0] S_EMIT_RD = 4'd6;
	localparam logic [3:0] S_EMIT_LD = 4'd7;
	localparam logic [3:0] S_FAIL    = 4'd8;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_op == OP_QUERY) begin
						cmd.start = 1'b1;
						state_d   = S_INIT;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_INIT: begin
				if (st.oob) begin
					state_d = S_FAIL;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) state_d = S_PICK;
			end
			S_PICK: begin
				if (!st.best_valid) begin
					state_d = S_FAIL;
				end else begin
					cmd.expand = 1'b1;
					state_d    = st.best_is_goal ? S_WALK : S_NB;
				end
			end
			S_NB: begin
				cmd.nb = 1'b1;
				if (st.nb_done) state_d = S_SCAN;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (st.walk_done) state_d = S_EMIT_RD;
			end
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				if (st.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = st.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_FAIL: begin
				if (st.out_free) begin
					cmd.fail = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/gaps_dp.sv
// ----------------------------------------------------------------------------
// gaps_dp: search datapath
// Map and open/closed bits, node memory, open-set scan, neighbour update,
// parent walk into a path memory, and the result register.
// ----------------------------------------------------------------------------
module gaps_dp
	import gaps_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t st,
	input  item_t   item_data,
	input  logic    cfg_we,
	input  cfg_t    cfg_data,
	input  logic    rsp_ready,
	output logic    rsp_valid,
	output result_t rsp_data
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W = IDX_W + 1;

	function automatic logic [IDX_W-1:0] cell_idx(input logic [COORD_W-1:0] r, c);
		logic [6:0] t;
		t = 7'(r) * 7'(MAX_COLS) + 7'(c);
		return IDX_W'(t);
	endfunction

	// configuration
	logic [3:0] map_rows_q, map_cols_q, rows_eff, cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= 4'd8;
			map_cols_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_data.index)
				REG_MAP_ROWS: map_rows_q <= cfg_data.data;
				REG_MAP_COLS: map_cols_q <= cfg_data.data;
				default: ;
			endcase
		end
	end

	assign rows_eff = (map_rows_q < 4'(MAX_ROWS)) ? map_rows_q : 4'(MAX_ROWS);
	assign cols_eff = (map_cols_q < 4'(MAX_COLS)) ? map_cols_q : 4'(MAX_COLS);

	// query coordinates
	logic [COORD_W-1:0] sr_q, sc_q, gr_q, gc_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sr_q <= item_data.cell_row;
			sc_q <= item_data.cell_col;
			gr_q <= item_data.goal_row;
			gc_q <= item_data.goal_col;
		end
	end

	assign st.oob = ({1'b0, sr_q} >= rows_eff) || ({1'b0, sc_q} >= cols_eff) ||
	                ({1'b0, gr_q} >= rows_eff) || ({1'b0, gc_q} >= cols_eff);

	// node memory: one read, one write per cycle
	node_t            node_mem [CELLS];
	node_t            rd_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic             wr_en;
	node_t            wr_node;

	always_ff @(posedge clk) begin
		if (wr_en) node_mem[wr_addr] <= wr_node;
		rd_q <= node_mem[rd_addr];
	end

	// scan of the open set
	logic [COORD_W-1:0] scan_r_q, scan_c_q, scan_r_s1, scan_c_s1;
	logic               scan_end_q, scan_issue, rd_valid_s1, open_s1;
	logic [COORD_W-1:0] best_r_q, best_c_q;
	node_t              best_q;
	logic               best_valid_q, better;

	assign scan_issue = cmd.scan && !scan_end_q;

	// neighbour update
	logic [2:0]         nb_i_q;
	logic               nb_ph_q;
	logic signed [1:0]  n_dr, n_dc;
	logic [3:0]         nr4, nc4;
	logic [COORD_W-1:0] n_r, n_c;
	logic [IDX_W-1:0]   n_idx;
	logic               n_ok, n_upd;
	logic [COST_W-1:0]  g_new, f_new;
	logic [COST_W-1:0]  stamp_q;

	// walk
	logic [COORD_W-1:0] cur_r_q, cur_c_q;
	logic               wk_ph_q;
	logic [CNT_W-1:0]   n_q, n_next;
	logic [IDX_W-1:0]   emit_idx_q;
	logic signed [1:0]  p_dr, p_dc;
	logic [3:0]         pr4, pc4;
	logic               wk_at_start, wk_full, wk_oob;

	// map, open and closed bits
	logic [CELLS-1:0] wall_q, open_q, closed_q;

	assign n_dr  = step_row(nb_i_q);
	assign n_dc  = step_col(nb_i_q);
	assign nr4   = {1'b0, best_r_q} + {{2{n_dr[1]}}, n_dr};
	assign nc4   = {1'b0, best_c_q} + {{2{n_dc[1]}}, n_dc};
	assign n_r   = nr4[COORD_W-1:0];
	assign n_c   = nc4[COORD_W-1:0];
	assign n_idx = cell_idx(n_r, n_c);
	assign n_ok  = !nr4[3] && (nr4 < rows_eff) && !nc4[3] && (nc4 < cols_eff) &&
	               !wall_q[n_idx] && !closed_q[n_idx];
	assign g_new = best_q.g + ((n_dr != 2'sd0 && n_dc != 2'sd0) ?
	               COST_W'(STEP_DIAGONAL) : COST_W'(STEP_STRAIGHT));
	assign f_new = g_new + octile(n_r, n_c, gr_q, gc_q);
	assign n_upd = cmd.nb && nb_ph_q && n_ok && !(open_q[n_idx] && rd_q.f <= f_new);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = n_idx;
		wr_node = '{g: g_new, f: f_new, stamp: stamp_q, parent: nb_i_q};
		if (cmd.init) begin
			wr_en   = 1'b1;
			wr_addr = cell_idx(sr_q, sc_q);
			wr_node = '{g: '0, f: octile(sr_q, sc_q, gr_q, gc_q), stamp: '0, parent: DIR_NW};
		end else if (n_upd) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		if (cmd.scan)    rd_addr = cell_idx(scan_r_q, scan_c_q);
		else if (cmd.nb) rd_addr = n_idx;
		else             rd_addr = cell_idx(cur_r_q, cur_c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_q   <= '0;
			open_q   <= '0;
			closed_q <= '0;
		end else begin
			if (cmd.load && ({1'b0, item_data.cell_row} < 4'(MAX_ROWS)) &&
			    ({1'b0, item_data.cell_col} < 4'(MAX_COLS)))
				wall_q[cell_idx(item_data.cell_row, item_data.cell_col)] <= item_data.wall;
			if (cmd.start) begin
				open_q   <= '0;
				closed_q <= '0;
			end
			if (cmd.init) open_q[cell_idx(sr_q, sc_q)] <= 1'b1;
			if (cmd.expand) begin
				open_q[cell_idx(best_r_q, best_c_q)]   <= 1'b0;
				closed_q[cell_idx(best_r_q, best_c_q)] <= 1'b1;
			end
			if (n_upd) open_q[n_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init)      stamp_q <= COST_W'(1);
		else if (n_upd)    stamp_q <= stamp_q + COST_W'(1);
	end

	// scan counters and the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			scan_end_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_issue;
			if (!cmd.scan) begin
				scan_r_q   <= '0;
				scan_c_q   <= '0;
				scan_end_q <= 1'b0;
			end else if (scan_issue) begin
				if (scan_c_q == COORD_W'(MAX_COLS - 1)) begin
					scan_c_q <= '0;
					if (scan_r_q == COORD_W'(MAX_ROWS - 1)) scan_end_q <= 1'b1;
					else scan_r_q <= scan_r_q + COORD_W'(1);
				end else begin
					scan_c_q <= scan_c_q + COORD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_r_s1 <= scan_r_q;
		scan_c_s1 <= scan_c_q;
		open_s1   <= open_q[cell_idx(scan_r_q, scan_c_q)];
	end

	assign better = !best_valid_q || (rd_q.f < best_q.f) ||
	                ((rd_q.f == best_q.f) && (rd_q.stamp < best_q.stamp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (cmd.scan && !scan_end_q && scan_r_q == '0 && scan_c_q == '0 &&
		             !rd_valid_s1) begin
			best_valid_q <= 1'b0;
		end else if (rd_valid_s1 && open_s1 && better) begin
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && open_s1 && better) begin
			best_q   <= rd_q;
			best_r_q <= scan_r_s1;
			best_c_q <= scan_c_s1;
		end
	end

	assign st.scan_done    = scan_end_q && !rd_valid_s1;
	assign st.best_valid   = best_valid_q;
	assign st.best_is_goal = (best_r_q == gr_q) && (best_c_q == gc_q);

	// neighbour counters: read phase, then update phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_i_q  <= DIR_NW;
			nb_ph_q <= 1'b0;
		end else if (!cmd.nb) begin
			nb_i_q  <= DIR_NW;
			nb_ph_q <= 1'b0;
		end else begin
			nb_ph_q <= !nb_ph_q;
			if (nb_ph_q) nb_i_q <= nb_i_q + 3'd1;
		end
	end

	assign st.nb_done = cmd.nb && nb_ph_q && (nb_i_q == DIR_SE);

	// parent walk from goal back to start
	logic [2*COORD_W-1:0] path_mem [CELLS];
	logic [2*COORD_W-1:0] path_rd_q;

	assign n_next      = n_q + CNT_W'(1);
	assign wk_at_start = (cur_r_q == sr_q) && (cur_c_q == sc_q);
	assign wk_full     = (n_next == CNT_W'(CELLS));
	assign p_dr        = step_row(rd_q.parent);
	assign p_dc        = step_col(rd_q.parent);
	assign pr4         = {1'b0, cur_r_q} - {{2{p_dr[1]}}, p_dr};
	assign pc4         = {1'b0, cur_c_q} - {{2{p_dc[1]}}, p_dc};
	assign wk_oob      = pr4[3] || (pr4 >= 4'(MAX_ROWS)) || pc4[3] || (pc4 >= 4'(MAX_COLS));
	assign st.walk_done = cmd.walk && (wk_ph_q ? wk_oob : (wk_at_start || wk_full));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_ph_q <= 1'b0;
		end else if (!cmd.walk || st.walk_done) begin
			wk_ph_q <= 1'b0;
		end else begin
			wk_ph_q <= !wk_ph_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.expand) begin
			cur_r_q <= best_r_q;
			cur_c_q <= best_c_q;
			n_q     <= '0;
		end else if (cmd.walk && !wk_ph_q) begin
			path_mem[n_q[IDX_W-1:0]] <= {cur_r_q, cur_c_q};
			n_q <= n_next;
			if (wk_at_start || wk_full) emit_idx_q <= n_q[IDX_W-1:0];
		end else if (cmd.walk && wk_ph_q) begin
			if (wk_oob) begin
				emit_idx_q <= IDX_W'(n_q - CNT_W'(1));
			end else begin
				cur_r_q <= pr4[COORD_W-1:0];
				cur_c_q <= pc4[COORD_W-1:0];
			end
		end else if (cmd.emit_ld) begin
			emit_idx_q <= emit_idx_q - IDX_W'(1);
		end
		path_rd_q <= path_mem[emit_idx_q];
	end

	assign st.emit_last = (emit_idx_q == '0);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.emit_ld || cmd.fail) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			rsp_data <= '{path_row: path_rd_q[2*COORD_W-1:COORD_W],
			              path_col: path_rd_q[COORD_W-1:0],
			              found: 1'b1, last: (emit_idx_q == '0)};
		end else if (cmd.fail) begin
			rsp_data <= '{path_row: '0, path_col: '0, found: 1'b0, last: 1'b1};
		end
	end

	assign st.out_free = !rsp_valid || rsp_ready;

endmodule

FILE: rtl/grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_core: A* path search on an 8-connected grid
// Octile step costs, wall map loaded cell by cell, path emitted start to goal.
// ----------------------------------------------------------------------------
// channel  dir  payload                                       transfer
// item     in   operation cell_row cell_col wall goal_row/col  valid & ready
// result   out  path_row path_col found last                   valid & ready
// cfg      in   index data (0 map_rows, 1 map_cols)            valid & ready
//
// A load is written while the sequencer stays idle. A query runs setup, then per
// expansion an open-set scan through the single node memory read port and a
// neighbour update, then a parent walk and the emission of each path cell.
// Reset clears the wall map, open/closed bits and config (8 x 8) at once.
// A stalled result holds the search in emission; item is taken only when the
// sequencer is idle, while the last result may still wait in its register.
// ----------------------------------------------------------------------------
module grid_astar_path_search_core
	import gaps_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input logic         clk,
	input logic         arst_n,
	gaps_chan_if.sink   item,
	gaps_chan_if.source result,
	gaps_chan_if.sink   cfg
);

	cmd_t    cmd;
	status_t st;
	logic    item_ready;
	logic    rsp_valid;
	result_t rsp_data;

	// sequencer: owns the item handshake
	gaps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.payload.operation),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: storage, scan, update, walk and result register
	gaps_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.item_data (item.payload),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.payload),
		.rsp_ready (result.ready),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	assign item.ready     = item_ready;
	assign cfg.ready      = 1'b1;   // writes must arrive only while idle; the block does not enforce it
	assign result.valid   = rsp_valid;
	assign result.payload = rsp_data;

`ifndef NO_ASSERTIONS
	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start, cmd.init, cmd.scan, cmd.expand,
		          cmd.nb, cmd.walk, cmd.emit_ld, cmd.fail}))
		else $error("overlapping datapath commands");

	// a no-path result always closes the run
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.payload.found) |-> result.payload.last)
		else $error("no-path result without last");

	// a load leaves the sequencer ready for the next item
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> item.ready)
		else $error("load did not return to idle");
`endif

endmodule

FILE: dv/tb_grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search_core: self-checking bench of the grid path search
// Loads wall maps, runs path queries under several grid sizes and compares
// every emitted path cell with an in-bench A* predictor, while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search_core;
	import gaps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID       = 8;
	localparam int CELL_COUNT = GRID * GRID;
	localparam int CYCLE_CAP  = 6000000;
	localparam int SETTLE     = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gaps_chan_if #(.payload_t(item_t))   item_ch ();
	gaps_chan_if #(.payload_t(result_t)) result_ch ();
	gaps_chan_if #(.payload_t(cfg_t))    cfg_ch ();

	grid_astar_path_search_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// bench copy of the block state
	logic [3:0] rows_reg = 4'd8;
	logic [3:0] cols_reg = 4'd8;
	bit         walls[CELL_COUNT];
	result_t    path_cells_due[$];

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;

	// neighbour scan order, (row step, column step)
	const int ROW_STEP[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
	const int COL_STEP[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

	function automatic int octile_cost(input int r0, c0, r1, c1);
		int dr, dc, lo, hi;
		dr = r0 > r1 ? r0 - r1 : r1 - r0;
		dc = c0 > c1 ? c0 - c1 : c1 - c0;
		lo = dr < dc ? dr : dc;
		hi = dr < dc ? dc : dr;
		return lo * STEP_DIAGONAL + (hi - lo) * STEP_STRAIGHT;
	endfunction

	function automatic void push_no_path();
		result_t r;
		r = '{path_row: '0, path_col: '0, found: 1'b0, last: 1'b1};
		path_cells_due.insert(path_cells_due.size(), r);
	endfunction

	// A* as the block runs it: least f, ties to earliest (re)insertion
	function automatic void predict_path(input item_t it);
		int rows, cols, sr, sc, gr, gc, best, r, c, nr, nc, ni, g, f, n, cur, d, stamp;
		bit opn[CELL_COUNT];
		bit cls[CELL_COUNT];
		int gcost[CELL_COUNT];
		int fest[CELL_COUNT];
		int stmp[CELL_COUNT];
		int par[CELL_COUNT];
		int trail[CELL_COUNT];
		result_t res;
		rows = rows_reg < GRID ? rows_reg : GRID;
		cols = cols_reg < GRID ? cols_reg : GRID;
		sr = it.cell_row; sc = it.cell_col;
		gr = it.goal_row; gc = it.goal_col;
		if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) begin
			push_no_path();
			return;
		end
		foreach (opn[i]) begin
			opn[i] = 0;
			cls[i] = 0;
		end
		cur = sr * GRID + sc;
		opn[cur] = 1;
		gcost[cur] = 0;
		fest[cur] = octile_cost(sr, sc, gr, gc);
		stmp[cur] = 0;
		par[cur] = 0;
		stamp = 1;
		while (1) begin
			best = -1;
			for (int i = 0; i < CELL_COUNT; i++) begin
				if (opn[i] && (best < 0 || fest[i] < fest[best] ||
						(fest[i] == fest[best] && stmp[i] < stmp[best])))
					best = i;
			end
			if (best < 0) begin
				push_no_path();
				return;
			end
			opn[best] = 0;
			cls[best] = 1;
			r = best / GRID;
			c = best % GRID;
			if (r == gr && c == gc) break;
			for (int k = 0; k < 8; k++) begin
				nr = r + ROW_STEP[k];
				nc = c + COL_STEP[k];
				if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
				ni = nr * GRID + nc;
				if (walls[ni] || cls[ni]) continue;
				g = gcost[best] + octile_cost(r, c, nr, nc);
				f = g + octile_cost(nr, nc, gr, gc);
				if (opn[ni] && fest[ni] <= f) continue;
				opn[ni] = 1;
				gcost[ni] = g & 10'h3ff;
				fest[ni] = f & 10'h3ff;
				stmp[ni] = stamp & 10'h3ff;
				stamp++;
				par[ni] = k;
			end
		end
		// walk parents back from the goal
		n = 0;
		cur = gr * GRID + gc;
		while (n < CELL_COUNT) begin
			r = cur / GRID;
			c = cur % GRID;
			trail[n++] = cur;
			if (r == sr && c == sc) break;
			d = par[cur];
			r -= ROW_STEP[d];
			c -= COL_STEP[d];
			if (r < 0 || r >= GRID || c < 0 || c >= GRID) break;
			cur = r * GRID + c;
		end
		for (int k = 0; k < n; k++) begin
			res.path_row = COORD_W'(trail[n - 1 - k] / GRID);
			res.path_col = COORD_W'(trail[n - 1 - k] % GRID);
			res.found = 1'b1;
			res.last = (k == n - 1);
			path_cells_due.insert(path_cells_due.size(), res);
		end
	endfunction

	// one item transfer; valid stays high inside a burst
	task automatic send_item(input item_t it);
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		if (it.operation == OP_LOAD)
			walls[it.cell_row * GRID + it.cell_col] = it.wall;
		else
			predict_path(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 6);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
	endtask

	task automatic send_load(input int r, c, input bit w);
		item_t it;
		it = '{operation: OP_LOAD, cell_row: r[2:0], cell_col: c[2:0], wall: w,
			goal_row: 3'($urandom), goal_col: 3'($urandom)};
		send_item(it);
	endtask

	task automatic send_query(input int sr, sc, gr, gc);
		item_t it;
		it = '{operation: OP_QUERY, cell_row: sr[2:0], cell_col: sc[2:0],
			wall: 1'($urandom), goal_row: gr[2:0], goal_col: gc[2:0]};
		send_item(it);
	endtask

	// hold the sender until every path cell has come back, then let the core settle
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (path_cells_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MAP_ROWS) rows_reg = val;
		else cols_reg = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_grid(input logic [3:0] r, c);
		write_reg(REG_MAP_ROWS, r);
		write_reg(REG_MAP_COLS, c);
	endtask

	task automatic clear_map();
		for (int i = 0; i < CELL_COUNT; i++)
			if (walls[i]) send_load(i / GRID, i % GRID, 1'b0);
	endtask

	// corners, start equal to goal, walls on start and goal, blocked goal
	task automatic test_directed();
		send_query(0, 0, 7, 7);
		send_query(7, 7, 0, 0);
		send_query(3, 4, 3, 4);
		send_load(7, 7, 1'b1);
		send_query(0, 0, 7, 7);
		send_query(7, 7, 7, 7);
		send_load(0, 0, 1'b1);
		send_query(0, 0, 2, 5);
		// ring of walls around (7,7): goal unreachable
		send_load(7, 7, 1'b0);
		send_load(6, 6, 1'b1);
		send_load(6, 7, 1'b1);
		send_load(7, 6, 1'b1);
		send_query(0, 7, 7, 7);
		// diagonal squeeze between two walls
		send_load(1, 2, 1'b1);
		send_load(2, 1, 1'b1);
		send_query(1, 1, 2, 2);
		clear_map();
	endtask

	// grid bounds from the registers, out-of-range start and goal
	task automatic test_bounds();
		set_grid(4'd3, 4'd5);
		send_query(0, 0, 2, 4);
		send_query(3, 0, 0, 0);
		send_query(0, 0, 0, 5);
		set_grid(4'd0, 4'd15);
		send_query(0, 0, 0, 0);
		set_grid(4'd1, 4'd1);
		send_query(0, 0, 0, 0);
		send_query(0, 0, 0, 1);
		set_grid(4'd8, 4'd8);
	endtask

	// random walls mixed with mostly in-range queries
	task automatic test_random_maps(input logic [3:0] r, c, input int count);
		int rr, cc, density;
		set_grid(r, c);
		rr = r < GRID ? (r == 0 ? 1 : r) : GRID;
		cc = c < GRID ? (c == 0 ? 1 : c) : GRID;
		density = $urandom_range(10, 45);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				send_load($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 99) < density);
			end else if ($urandom_range(0, 9) == 0) begin
				send_query($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7));
			end else begin
				send_query($urandom_range(0, rr - 1), $urandom_range(0, cc - 1),
					$urandom_range(0, rr - 1), $urandom_range(0, cc - 1));
			end
		end
		drain();
	endtask

	// result sink stalls on its own pattern, with stretches of full rate
	int stall_mode = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom);
			2: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// compare each path cell with the oldest one due
	always @(posedge clk) begin
		result_t due;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (path_cells_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", result_ch.payload);
			end else begin
				due = path_cells_due.pop_front();
				if (result_ch.payload !== due) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p got %p", due, result_ch.payload);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		result_ch.ready = 1'b0;
		foreach (walls[i]) walls[i] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_bounds();
		test_random_maps(4'd8, 4'd8, 70);
		test_random_maps(4'd1, 4'd8, 40);
		test_random_maps(4'd8, 4'd1, 40);
		test_random_maps(4'd3, 4'd5, 50);
		test_random_maps(4'd15, 4'd15, 60);
		test_random_maps(4'd0, 4'd4, 20);
		test_random_maps(4'd6, 4'd7, 60);
		test_random_maps(4'd2, 4'd2, 30);
		test_random_maps(4'd8, 4'd8, 70);
		drain();

		if (errors == 0 && path_cells_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: grid_astar_path_search_core.f
rtl/gaps_pkg.sv
rtl/gaps_chan_if.sv
rtl/gaps_ctrl.sv
rtl/gaps_dp.sv
rtl/grid_astar_path_search_core.sv
dv/tb_grid_astar_path_search_core.sv
